>>> hw/rtl/gfe_pkg.sv
// Shared types, constants and the exp table generator for the Gaussian field evaluator.
// No dependencies.
package gfe_pkg;

	localparam int MAX_GAUSSIANS_DEF   = 256;
	localparam int EXP_TABLE_DEPTH_DEF = 1024;
	localparam int FIELD_W  = 24;
	localparam int CFG_W    = 9;
	localparam int SLOT_W   = 8;
	localparam int OUT_W    = 32;
	localparam int E_W      = 17;
	localparam int ROOT_ITERS = 32;
	localparam logic [63:0] INV_E_Q32 = 64'd1580030169;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_SQR,
		ST_ROOT,
		ST_DONE
	} gfe_state_t;

	// exp(-a) in Q1.16, a given in Q.32
	function automatic logic [E_W-1:0] exp_entry(input logic [63:0] a32);
		logic [63:0] whole;
		logic [63:0] f;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] rnd;
		whole = a32 >> 32;
		f     = {32'd0, a32[31:0]};
		term  = 64'd1 << 32;
		sum   = term;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * f) >> 32) / 64'(k);
			if ((k % 2) == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		for (int k = 0; k < 8; k++) begin
			if (64'(k) < whole)
				sum = (sum * INV_E_Q32) >> 32;
		end
		rnd = (sum + 64'd32768) >> 16;
		return rnd[E_W-1:0];
	endfunction

endpackage

>>> hw/rtl/gaussian_field_evaluate_unit.sv
// Top level of the Gaussian field evaluator: slot memory, per-slot pipeline, norm and root.
// Depends on gfe_pkg.
// A query walks the n slots through the per-slot pipeline, then squares the gradient axes
// and takes a bit-serial root; one item at a time, since input is taken only while the
// sequencer is idle. Loads write slot memory when accepted. A result waits in the output register while the
// next item enters. Reset clears control state and the slot count; slot memory holds garbage.
module gaussian_field_evaluate_unit #(
	parameter int MAX_GAUSSIANS   = gfe_pkg::MAX_GAUSSIANS_DEF,
	parameter int EXP_TABLE_DEPTH = gfe_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              command,
	input  logic [gfe_pkg::SLOT_W-1:0]        slot,
	input  logic signed [gfe_pkg::FIELD_W-1:0] pos_x,
	input  logic signed [gfe_pkg::FIELD_W-1:0] pos_y,
	input  logic signed [gfe_pkg::FIELD_W-1:0] pos_z,
	input  logic [gfe_pkg::FIELD_W-1:0]       inv_scale_x,
	input  logic [gfe_pkg::FIELD_W-1:0]       inv_scale_y,
	input  logic [gfe_pkg::FIELD_W-1:0]       inv_scale_z,
	input  logic signed [gfe_pkg::FIELD_W-1:0] weight,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [gfe_pkg::OUT_W-1:0]  field_value,
	output logic [gfe_pkg::OUT_W-1:0]         gradient_norm,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gfe_pkg::CFG_W-1:0]         gaussians_in_use
);
	import gfe_pkg::*;

	localparam int AW    = (MAX_GAUSSIANS > 1) ? $clog2(MAX_GAUSSIANS) : 1;
	localparam int CW0   = $clog2(MAX_GAUSSIANS + 1);
	localparam int CW    = (CW0 > CFG_W) ? CW0 : CFG_W;
	localparam int IDXW  = $clog2(EXP_TABLE_DEPTH);
	localparam int ACC_W = 42 + AW + 1;
	localparam int GW    = 48 + AW + 1;
	localparam int VW    = ACC_W - 16;
	localparam int MEM_W = 7 * FIELD_W;
	localparam int NV    = 9;
	localparam int RCW   = $clog2(ROOT_ITERS);

	// exp table, registered read
	logic [E_W-1:0] exp_rom [EXP_TABLE_DEPTH];
	for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
		localparam logic [63:0] A32 = ((64'(i) * 64'd8) << 32) / EXP_TABLE_DEPTH;
		assign exp_rom[i] = exp_entry(A32);
	end

	gfe_state_t state_q, state_d;
	logic [CW-1:0]  cfg_q, n_q, cnt_q;
	logic [NV-1:0]  vld_q;
	logic [1:0]     ax_q;
	logic [RCW-1:0] rt_cnt_q;
	logic           out_valid_q;
	logic           issue, sq_en, rt_en, load_out, accept;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	// slot memory
	logic [MEM_W-1:0] mem [MAX_GAUSSIANS];
	logic [MEM_W-1:0] rd_q;
	logic             mem_we;
	logic [AW-1:0]    wr_addr;

	assign mem_we  = accept && (command == CMD_LOAD) && (CW'(slot) < CW'(MAX_GAUSSIANS));
	assign wr_addr = AW'(slot);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= {weight, inv_scale_z, inv_scale_y, inv_scale_x, pos_z, pos_y, pos_x};
		rd_q <= mem[cnt_q[AW-1:0]];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && command == CMD_QUERY) state_d = ST_RUN;
			ST_RUN:  if (cnt_q == n_q && vld_q == '0) state_d = ST_SQR;
			ST_SQR:  if (ax_q == 2'd3) state_d = ST_ROOT;
			ST_ROOT: if (rt_cnt_q == RCW'(ROOT_ITERS - 1)) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		sq_en    = 1'b0;
		rt_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_RUN:  issue    = (cnt_q != n_q);
			ST_SQR:  sq_en    = 1'b1;
			ST_ROOT: rt_en    = 1'b1;
			ST_DONE: load_out = !out_valid_q;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			vld_q       <= '0;
			ax_q        <= '0;
			rt_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				cfg_q <= CW'(gaussians_in_use);
			if (accept && command == CMD_QUERY) begin
				n_q   <= (cfg_q > CW'(MAX_GAUSSIANS)) ? CW'(MAX_GAUSSIANS) : cfg_q;
				cnt_q <= '0;
				ax_q  <= '0;
				rt_cnt_q <= '0;
			end
			if (issue)
				cnt_q <= cnt_q + 1'b1;
			vld_q <= {vld_q[NV-2:0], issue};
			if (sq_en)
				ax_q <= ax_q + 1'b1;
			if (rt_en)
				rt_cnt_q <= rt_cnt_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// per-slot pipeline
	logic signed [FIELD_W-1:0] q_q [3];
	logic signed [24:0] d_s2 [3];
	logic [FIELD_W-1:0] inv_s2 [3], inv_s3 [3];
	logic signed [FIELD_W-1:0] w_s2, w_s3, w_s4, w_s5, w_s6;
	logic [33:0] sq_s3 [3];
	logic signed [37:0] dxi_s3 [3], dxi_s4 [3], dxi_s5 [3], dxi_s6 [3], dxi_s7 [3];
	logic [45:0] part_s4 [3];
	logic [IDXW-1:0] idx_s5;
	logic far_s5, far_s6;
	logic [E_W-1:0] e_s6;
	logic signed [41:0] wc_s7;
	logic signed [46:0] ph_s8 [3];
	logic signed [45:0] pl_s8 [3];
	logic signed [63:0] prod_s9 [3];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [GW-1:0] g_q [3];

	logic [47:0] dsq;
	logic [33:0] idx_prod;
	logic signed [26:0] nwe;

	assign dsq      = 48'(part_s4[0]) + 48'(part_s4[1]) + 48'(part_s4[2]);
	assign idx_prod = 34'(dsq[19:0]) * 34'(EXP_TABLE_DEPTH);
	assign nwe      = -$signed({wc_s7[41], wc_s7[41:16]});

	always_ff @(posedge clk) begin
		logic [FIELD_W-1:0] mfield;
		logic [24:0]        mag;
		logic [49:0]        mm;
		logic signed [49:0] dinv;
		logic [57:0]        si;
		logic [E_W-1:0]     e_eff;
		if (accept) begin
			q_q[0] <= pos_x;
			q_q[1] <= pos_y;
			q_q[2] <= pos_z;
		end
		for (int a = 0; a < 3; a++) begin
			mfield = rd_q[a*FIELD_W +: FIELD_W];
			d_s2[a]   <= $signed({q_q[a][FIELD_W-1], q_q[a]}) - $signed({mfield[FIELD_W-1], mfield});
			inv_s2[a] <= rd_q[(a+3)*FIELD_W +: FIELD_W];
			mag   = d_s2[a][24] ? 25'(-d_s2[a]) : 25'(d_s2[a]);
			mm    = 50'(mag) * 50'(mag);
			dinv  = d_s2[a] * $signed({1'b0, inv_s2[a]});
			sq_s3[a]  <= mm[49:16];
			dxi_s3[a] <= dinv[49:12];
			inv_s3[a] <= inv_s2[a];
			si    = 58'(sq_s3[a]) * 58'(inv_s3[a]);
			part_s4[a] <= si[57:12];
			dxi_s4[a]  <= dxi_s3[a];
			dxi_s5[a]  <= dxi_s4[a];
			dxi_s6[a]  <= dxi_s5[a];
			dxi_s7[a]  <= dxi_s6[a];
			ph_s8[a]   <= nwe * $signed(dxi_s7[a][37:18]);
			pl_s8[a]   <= nwe * $signed({1'b0, dxi_s7[a][17:0]});
			prod_s9[a] <= ($signed(64'(ph_s8[a])) <<< 18) + 64'(pl_s8[a]);
		end
		w_s2   <= $signed(rd_q[6*FIELD_W +: FIELD_W]);
		w_s3   <= w_s2;
		w_s4   <= w_s3;
		w_s5   <= w_s4;
		w_s6   <= w_s5;
		idx_s5 <= idx_prod[20 +: IDXW];
		far_s5 <= |dsq[47:20];
		e_s6   <= exp_rom[idx_s5];
		far_s6 <= far_s5;
		e_eff  = far_s6 ? '0 : e_s6;
		wc_s7  <= w_s6 * $signed({1'b0, e_eff});
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= '0;
			for (int a = 0; a < 3; a++)
				g_q[a] <= '0;
		end else begin
			if (vld_q[6])
				acc_q <= acc_q + ACC_W'(wc_s7);
			if (vld_q[8])
				for (int a = 0; a < 3; a++)
					g_q[a] <= g_q[a] + GW'($signed(prod_s9[a][63:16]));
		end
	end

	// gradient norm: squares then bit-serial root
	logic [1:0]    gsel;
	logic [GW-1:0] gmag;
	logic [63:0]   sq_q, val_q;
	logic [65:0]   sum_q;
	logic          big_q;
	logic [33:0]   rem_q, rem_n, trial;
	logic [31:0]   root_q;
	logic          sat;

	assign gsel  = (ax_q == 2'd3) ? 2'd0 : ax_q;
	assign gmag  = g_q[gsel][GW-1] ? GW'(-g_q[gsel]) : GW'(g_q[gsel]);
	assign rem_n = {rem_q[31:0], val_q[63:62]};
	assign trial = {root_q, 2'b01};
	assign sat   = big_q || (sum_q[65:64] != 2'b00);

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= '0;
			big_q <= 1'b0;
		end
		if (sq_en) begin
			if (ax_q != 2'd3) begin
				sq_q <= 64'(gmag[31:0]) * 64'(gmag[31:0]);
				if (|gmag[GW-1:32])
					big_q <= 1'b1;
			end
			if (ax_q != 2'd0)
				sum_q <= sum_q + 66'(sq_q);
			if (ax_q == 2'd3) begin
				val_q  <= sum_q[63:0] + sq_q;
				rem_q  <= '0;
				root_q <= '0;
				if ((sum_q + 66'(sq_q)) >> 64 != 66'd0)
					big_q <= 1'b1;
			end
		end
		if (rt_en) begin
			val_q <= {val_q[61:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	// result register
	logic signed [VW-1:0] fv;
	logic                 fv_ovf;

	assign fv     = acc_q[ACC_W-1:16];
	assign fv_ovf = (fv[VW-1:31] != {(VW-31){1'b0}}) && (fv[VW-1:31] != {(VW-31){1'b1}});

	always_ff @(posedge clk) begin
		if (load_out) begin
			field_value   <= fv_ovf ? (fv[VW-1] ? 32'sh80000000 : 32'sh7fffffff) : fv[31:0];
			gradient_norm <= sat ? 32'hffffffff : root_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (vld_q == '0))
		else $error("slot pipeline busy while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (cnt_q <= n_q))
		else $error("slot read beyond count");
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("result not held");

endmodule

>>> bench/tb.sv
// Self-checking bench for gaussian_field_evaluate_unit: loads, queries and slot-count writes.
// Holds its own fixed-point model of the Gaussian sum and gradient norm.
// Depends on gfe_pkg and the unit's RTL.
typedef logic signed [gfe_pkg::FIELD_W-1:0] coord_t;
typedef logic [gfe_pkg::FIELD_W-1:0] scale_t;

class field_ledger;
	typedef struct {
		logic signed [gfe_pkg::OUT_W-1:0] field;
		logic [gfe_pkg::OUT_W-1:0] norm;
	} field_result_t;

	logic [16:0] decay_lut[gfe_pkg::EXP_TABLE_DEPTH_DEF];
	coord_t mean_x[gfe_pkg::MAX_GAUSSIANS_DEF];
	coord_t mean_y[gfe_pkg::MAX_GAUSSIANS_DEF];
	coord_t mean_z[gfe_pkg::MAX_GAUSSIANS_DEF];
	scale_t inv_x[gfe_pkg::MAX_GAUSSIANS_DEF];
	scale_t inv_y[gfe_pkg::MAX_GAUSSIANS_DEF];
	scale_t inv_z[gfe_pkg::MAX_GAUSSIANS_DEF];
	coord_t wt[gfe_pkg::MAX_GAUSSIANS_DEF];
	int unsigned slot_count;
	field_result_t pending_fields[$];
	int errors;
	int results_seen;

	function new();
		for (int i = 0; i < gfe_pkg::EXP_TABLE_DEPTH_DEF; i++)
			decay_lut[i] = decay_at(i);
		slot_count = 0;
		errors = 0;
		results_seen = 0;
	endfunction

	// exp(-8i/depth) in Q1.16 from a Q.32 series
	function logic [16:0] decay_at(int i);
		logic [63:0] a32, whole, f, term, acc;
		a32 = ((64'(unsigned'(i)) * 64'd8) << 32) / 64'(gfe_pkg::EXP_TABLE_DEPTH_DEF);
		whole = a32 >> 32;
		f = {32'd0, a32[31:0]};
		term = 64'd1 << 32;
		acc = term;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * f) >> 32) / 64'(k);
			if (k % 2 == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		for (longint unsigned k = 0; k < whole; k++)
			acc = (acc * gfe_pkg::INV_E_Q32) >> 32;
		acc = (acc + 64'd32768) >> 16;
		return acc[16:0];
	endfunction

	function longint unsigned root64(longint unsigned v);
		longint unsigned res, probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function field_result_t evaluate_point(coord_t px, coord_t py, coord_t pz);
		field_result_t r;
		longint q[3], d[3], inv[3], g[3];
		longint acc, wc, we, v;
		longint unsigned dsq, m, e;
		logic [64:0] tot;
		bit sat;
		int n;
		q[0] = px;
		q[1] = py;
		q[2] = pz;
		g = '{0, 0, 0};
		acc = 0;
		n = slot_count > gfe_pkg::MAX_GAUSSIANS_DEF ? gfe_pkg::MAX_GAUSSIANS_DEF : slot_count;
		for (int s = 0; s < n; s++) begin
			d[0] = q[0] - longint'(mean_x[s]);
			d[1] = q[1] - longint'(mean_y[s]);
			d[2] = q[2] - longint'(mean_z[s]);
			inv[0] = longint'({40'd0, inv_x[s]});
			inv[1] = longint'({40'd0, inv_y[s]});
			inv[2] = longint'({40'd0, inv_z[s]});
			dsq = 0;
			for (int a = 0; a < 3; a++) begin
				m = d[a] < 0 ? -d[a] : d[a];
				dsq += (((m * m) >> 16) * longint'(inv[a])) >> 12;
			end
			e = dsq >= (64'd16 << 16) ? 0 : decay_lut[(dsq * 1024) >> 20];
			wc = longint'(wt[s]) * longint'(e);
			acc += wc;
			we = wc >>> 16;
			for (int a = 0; a < 3; a++)
				g[a] += ((-we) * ((d[a] * inv[a]) >>> 12)) >>> 16;
		end
		v = acc >>> 16;
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		r.field = v[31:0];
		tot = 0;
		sat = 0;
		for (int a = 0; a < 3; a++) begin
			m = g[a] < 0 ? -g[a] : g[a];
			if (m >= (64'd1 << 32))
				sat = 1;
			else
				tot = tot + {1'b0, m * m};
			if (tot[64])
				sat = 1;
		end
		r.norm = sat ? 32'hFFFF_FFFF : 32'(root64(tot[63:0]));
		return r;
	endfunction

	function void note_request(logic cmd, logic [7:0] s, coord_t px, coord_t py, coord_t pz,
			scale_t ix, scale_t iy, scale_t iz, coord_t w);
		if (cmd == gfe_pkg::CMD_LOAD) begin
			mean_x[s] = px;
			mean_y[s] = py;
			mean_z[s] = pz;
			inv_x[s] = ix;
			inv_y[s] = iy;
			inv_z[s] = iz;
			wt[s] = w;
		end else begin
			pending_fields = {pending_fields, evaluate_point(px, py, pz)};
		end
	endfunction

	function void check_result(logic signed [31:0] field, logic [31:0] norm);
		field_result_t x;
		results_seen++;
		if (pending_fields.size() == 0) begin
			$error("result with no query outstanding: field_value %0d gradient_norm %0d",
				field, norm);
			errors++;
			return;
		end
		x = pending_fields.pop_front();
		if (field !== x.field) begin
			$error("field_value expected %0d actual %0d", x.field, field);
			errors++;
		end
		if (norm !== x.norm) begin
			$error("gradient_norm expected %0d actual %0d", x.norm, norm);
			errors++;
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam coord_t C_MAX = 24'sh7FFFFF;
	localparam coord_t C_MIN = 24'sh800000;
	localparam scale_t S_MAX = 24'hFFFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = gfe_pkg::CMD_LOAD;
	logic [gfe_pkg::SLOT_W-1:0] slot = '0;
	coord_t pos_x = '0, pos_y = '0, pos_z = '0;
	scale_t inv_scale_x = '0, inv_scale_y = '0, inv_scale_z = '0;
	coord_t weight = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [gfe_pkg::OUT_W-1:0] field_value;
	logic [gfe_pkg::OUT_W-1:0] gradient_norm;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [gfe_pkg::CFG_W-1:0] gaussians_in_use = '0;

	field_ledger ledger = new();
	int items_sent = 0;
	bit sender_calm = 0;
	bit pressed = 0;

	gaussian_field_evaluate_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .slot(slot),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.inv_scale_x(inv_scale_x), .inv_scale_y(inv_scale_y), .inv_scale_z(inv_scale_z),
		.weight(weight),
		.out_valid(out_valid), .out_ready(out_ready),
		.field_value(field_value), .gradient_norm(gradient_norm),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.gaussians_in_use(gaussians_in_use)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("gaussian_field_evaluate_unit regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_result(field_value, gradient_norm);
	end

	// receiver: short stalls, occasional long ones, one long hold-off
	initial begin
		int r;
		bit calm;
		calm = 0;
		forever begin
			@(posedge clk);
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 199) == 0)
				calm = !calm;
			if (!pressed && ledger.results_seen >= 40) begin
				pressed = 1;
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else if (!calm && r < 3) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end else begin
				out_ready <= calm || r >= 25;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(logic cmd, logic [7:0] s, coord_t px, coord_t py, coord_t pz,
			scale_t ix, scale_t iy, scale_t iz, coord_t w);
		int gap;
		command <= cmd;
		slot <= s;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		inv_scale_x <= ix;
		inv_scale_y <= iy;
		inv_scale_z <= iz;
		weight <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		ledger.note_request(cmd, s, px, py, pz, ix, iy, iz, w);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_slot(logic [7:0] s, coord_t mx, coord_t my, coord_t mz,
			scale_t ix, scale_t iy, scale_t iz, coord_t w);
		send_item(gfe_pkg::CMD_LOAD, s, mx, my, mz, ix, iy, iz, w);
	endtask

	// unused fields of a query carry random bits
	task automatic ask_point(coord_t px, coord_t py, coord_t pz);
		send_item(gfe_pkg::CMD_QUERY, 8'($urandom), px, py, pz,
			24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
	endtask

	task automatic write_count(logic [gfe_pkg::CFG_W-1:0] v);
		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.pending_fields.size() != 0);
		repeat (16) @(posedge clk);
		gaussians_in_use <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ledger.slot_count = v;
	endtask

	function automatic coord_t rand_mean();
		if ($urandom_range(0, 99) < 80)
			return 24'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
		return 24'($urandom);
	endfunction

	function automatic scale_t rand_scale();
		if ($urandom_range(0, 99) < 80)
			return 24'($urandom_range(0, 24'h3000));
		return 24'($urandom);
	endfunction

	function automatic coord_t nudge(coord_t c);
		return c + 24'($signed($urandom_range(0, 24'h40000)) - 32'sh20000);
	endfunction

	initial begin
		int r, n, j, top;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then a handful of hand-made slots
		write_count(0);
		ask_point(C_MAX, C_MAX, C_MAX);
		ask_point(C_MIN, C_MIN, C_MIN);
		load_slot(8'd0, 0, 0, 0, 24'h001000, 24'h001000, 24'h001000, C_MAX);
		load_slot(8'd1, C_MIN, C_MIN, C_MIN, S_MAX, S_MAX, S_MAX, C_MIN);
		load_slot(8'd2, 0, 0, 0, 0, 0, 0, -24'sh10000);
		load_slot(8'd3, C_MAX, C_MAX, C_MAX, 24'h000800, 24'h000800, 24'h000800, 0);
		load_slot(8'd255, rand_mean(), rand_mean(), rand_mean(), S_MAX, 0, S_MAX, C_MAX);
		write_count(4);
		ask_point(0, 0, 0);
		ask_point(24'sh40000, 0, 0);
		ask_point(24'sh3FFFF, 0, 0);
		ask_point(-24'sh3FFFF, 24'sh1000, 0);
		ask_point(C_MAX, C_MAX, C_MAX);
		ask_point(C_MIN, C_MIN, C_MIN);
		ask_point(24'sd255, 24'sd255, 24'sd255);

		// full table with extreme weights: saturating norm and the most positive and most negative field
		for (int pass = 0; pass < 2; pass++) begin
			for (int s = 0; s < gfe_pkg::MAX_GAUSSIANS_DEF; s++)
				load_slot(8'(s), 0, 0, 0, S_MAX, S_MAX, S_MAX, pass ? C_MIN : C_MAX);
			write_count(pass ? 9'd256 : 9'd511);
			ask_point(0, 0, 0);
			ask_point(24'sd255, 24'sd255, 24'sd255);
			ask_point(-24'sd255, 24'sd3, 0);
		end

		while (items_sent < 1500) begin
			sender_calm = $urandom_range(0, 3) == 0;
			r = $urandom_range(0, 99);
			if (r < 85)
				n = $urandom_range(0, 16);
			else if (r < 95)
				n = $urandom_range(17, 255);
			else
				n = $urandom_range(256, 511);
			write_count(9'(n));
			top = n == 0 ? 0 : (n > 256 ? 255 : n - 1);
			repeat ($urandom_range(3, 12)) begin
				r = $urandom_range(0, 99);
				if (r < 25) begin
					j = $urandom_range(0, 99) < 70 ? $urandom_range(0, 15) : $urandom_range(0, 255);
					load_slot(8'(j), rand_mean(), rand_mean(), rand_mean(),
						rand_scale(), rand_scale(), rand_scale(), 24'($urandom));
				end else if (r < 85) begin
					j = $urandom_range(0, top);
					ask_point(nudge(ledger.mean_x[j]), nudge(ledger.mean_y[j]),
						nudge(ledger.mean_z[j]));
				end else begin
					ask_point(24'($urandom), 24'($urandom), 24'($urandom));
				end
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.pending_fields.size() != 0);
		repeat (400) @(posedge clk);
		if (ledger.errors == 0)
			$display("gaussian_field_evaluate_unit regression: pass");
		else
			$display("gaussian_field_evaluate_unit regression: fail");
		$finish;
	end
endmodule
